// File: hw/rtl/aac_pkg.sv
// shared constants and arctangent table for the axis-angle to rotation matrix block
package aac_pkg;

    // default field widths and cordic length
    localparam int DATA_BITS_DEFAULT     = 16;
    localparam int ANGLE_BITS_DEFAULT    = 16;
    localparam int CORDIC_STAGES_DEFAULT = 16;

    // phase word is 32 bits per turn, cordic x and y are Q2.30 with headroom
    localparam int PHASE_BITS = 32;
    localparam int XY_BITS    = 34;
    localparam int Z_BITS     = 33;
    // quaternion elements fit a signed 32-bit word, products are Q.60
    localparam int E_BITS     = 32;
    localparam int P_BITS     = 2 * E_BITS;
    localparam int S_BITS     = P_BITS + 2;
    // binary point of the products
    localparam int P_FRAC     = 60;

    // starting x: cordic gain compensation, 0.60725293 in Q.30
    localparam logic signed [XY_BITS-1:0] CORDIC_X0 = XY_BITS'(652032874);

    // atan(2^-i) in phase units of 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// File: hw/rtl/aac_cordic_cell.sv
// one rotation-mode cordic cell with its own pipeline register and handshake
module aac_cordic_cell #(
    parameter int DATA_BITS = aac_pkg::DATA_BITS_DEFAULT,
    parameter int STAGE     = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_in,
    output logic                                 ready_out,
    input  logic signed [aac_pkg::XY_BITS-1:0]   x_in,
    input  logic signed [aac_pkg::XY_BITS-1:0]   y_in,
    input  logic signed [aac_pkg::Z_BITS-1:0]    z_in,
    input  logic                                 upper_in,
    input  logic signed [DATA_BITS-1:0]          ax_in,
    input  logic signed [DATA_BITS-1:0]          ay_in,
    input  logic signed [DATA_BITS-1:0]          az_in,
    output logic                                 valid_out,
    input  logic                                 ready_in,
    output logic signed [aac_pkg::XY_BITS-1:0]   x_out,
    output logic signed [aac_pkg::XY_BITS-1:0]   y_out,
    output logic signed [aac_pkg::Z_BITS-1:0]    z_out,
    output logic                                 upper_out,
    output logic signed [DATA_BITS-1:0]          ax_out,
    output logic signed [DATA_BITS-1:0]          ay_out,
    output logic signed [DATA_BITS-1:0]          az_out
);
    import aac_pkg::*;

    localparam logic [4:0] K = 5'(STAGE % 32);
    localparam logic signed [Z_BITS-1:0] ATAN_K = Z_BITS'(ATAN_TURNS[K]);

    logic                      valid_reg;
    logic signed [XY_BITS-1:0] x_reg, x_next;
    logic signed [XY_BITS-1:0] y_reg, y_next;
    logic signed [Z_BITS-1:0]  z_reg, z_next;
    logic                      upper_reg;
    logic signed [DATA_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic signed [XY_BITS-1:0] dx, dy;
    logic                      load;

    // register is free when empty or when its item moves on
    assign ready_out = !valid_reg || ready_in;
    assign load      = ready_out && valid_in;

    // micro-rotation towards zero residual
    always_comb
    begin
        dx = y_in >>> K;
        dy = x_in >>> K;
        if (!z_in[Z_BITS-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_K;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_K;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            upper_reg <= upper_in;
            ax_reg    <= ax_in;
            ay_reg    <= ay_in;
            az_reg    <= az_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign upper_out = upper_reg;
    assign ax_out    = ax_reg;
    assign ay_out    = ay_reg;
    assign az_out    = az_reg;

endmodule

// File: hw/rtl/aac_matrix_pipe.sv
// quaternion, pairwise products and matrix elements over four pipeline registers
module aac_matrix_pipe #(
    parameter int DATA_BITS = aac_pkg::DATA_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid_in,
    output logic                               ready_out,
    input  logic signed [aac_pkg::XY_BITS-1:0] x_in,
    input  logic signed [aac_pkg::XY_BITS-1:0] y_in,
    input  logic                               upper_in,
    input  logic signed [DATA_BITS-1:0]        ax_in,
    input  logic signed [DATA_BITS-1:0]        ay_in,
    input  logic signed [DATA_BITS-1:0]        az_in,
    output logic                               valid_out,
    input  logic                               ready_in,
    output logic signed [DATA_BITS-1:0]        r00,
    output logic signed [DATA_BITS-1:0]        r01,
    output logic signed [DATA_BITS-1:0]        r02,
    output logic signed [DATA_BITS-1:0]        r10,
    output logic signed [DATA_BITS-1:0]        r11,
    output logic signed [DATA_BITS-1:0]        r12,
    output logic signed [DATA_BITS-1:0]        r20,
    output logic signed [DATA_BITS-1:0]        r21,
    output logic signed [DATA_BITS-1:0]        r22
);
    import aac_pkg::*;

    localparam int M_BITS    = DATA_BITS + XY_BITS;
    localparam int OUT_SHIFT = P_FRAC + 1 - DATA_BITS;
    localparam logic signed [M_BITS-1:0] E_HALF = M_BITS'(1) <<< (DATA_BITS - 2);
    localparam logic signed [S_BITS-1:0] S_HALF = S_BITS'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [S_BITS-1:0] R_HI   = (S_BITS'(1) <<< (DATA_BITS - 1)) - 1;
    localparam logic signed [S_BITS-1:0] R_LO   = -R_HI - 1;

    // round, shift down to Q1.(DATA_BITS-1) and saturate
    function automatic logic signed [DATA_BITS-1:0] finish(input logic signed [S_BITS-1:0] v);
        logic signed [S_BITS-1:0] r;
        r = (v + S_HALF) >>> OUT_SHIFT;
        if (r > R_HI)
            r = R_HI;
        if (r < R_LO)
            r = R_LO;
        return DATA_BITS'(r);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [XY_BITS-1:0] c_sel, s_sel;
    logic signed [M_BITS-1:0]  m1, m2, m3;
    logic signed [E_BITS-1:0]  e0_reg, e1_reg, e2_reg, e3_reg;
    logic signed [P_BITS-1:0]  p_reg [10];
    logic signed [S_BITS-1:0]  s_reg [9];
    logic signed [S_BITS-1:0]  s_next [9];
    logic signed [S_BITS-1:0]  pe [10];
    logic signed [DATA_BITS-1:0] r_reg [9];

    // ready chain, each register takes an item when empty or draining
    assign rdy4      = !v4_reg || ready_in;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign ready_out = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= valid_in;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // fold back the upper half turn and scale the axis by the sine
    always_comb
    begin
        c_sel = upper_in ? -y_in : x_in;
        s_sel = upper_in ? x_in : y_in;
        m1    = (M_BITS'(ax_in) * M_BITS'(s_sel) + E_HALF) >>> (DATA_BITS - 1);
        m2    = (M_BITS'(ay_in) * M_BITS'(s_sel) + E_HALF) >>> (DATA_BITS - 1);
        m3    = (M_BITS'(az_in) * M_BITS'(s_sel) + E_HALF) >>> (DATA_BITS - 1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && valid_in)
        begin
            e0_reg <= E_BITS'(c_sel);
            e1_reg <= E_BITS'(m1);
            e2_reg <= E_BITS'(m2);
            e3_reg <= E_BITS'(m3);
        end
    end

    // ten pairwise products of the quaternion
    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            p_reg[0] <= e0_reg * e0_reg;
            p_reg[1] <= e1_reg * e1_reg;
            p_reg[2] <= e2_reg * e2_reg;
            p_reg[3] <= e3_reg * e3_reg;
            p_reg[4] <= e0_reg * e1_reg;
            p_reg[5] <= e0_reg * e2_reg;
            p_reg[6] <= e0_reg * e3_reg;
            p_reg[7] <= e1_reg * e2_reg;
            p_reg[8] <= e1_reg * e3_reg;
            p_reg[9] <= e2_reg * e3_reg;
        end
    end

    // matrix element sums, off-diagonal ones doubled
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            pe[i] = S_BITS'(p_reg[i]);
        end
        s_next[0] = pe[0] + pe[1] - pe[2] - pe[3];
        s_next[1] = (pe[7] - pe[6]) <<< 1;
        s_next[2] = (pe[8] + pe[5]) <<< 1;
        s_next[3] = (pe[7] + pe[6]) <<< 1;
        s_next[4] = pe[0] - pe[1] + pe[2] - pe[3];
        s_next[5] = (pe[9] - pe[4]) <<< 1;
        s_next[6] = (pe[8] - pe[5]) <<< 1;
        s_next[7] = (pe[9] + pe[4]) <<< 1;
        s_next[8] = pe[0] - pe[1] - pe[2] + pe[3];
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                s_reg[i] <= s_next[i];
            end
        end
    end

    // rounding and saturation into the output register
    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                r_reg[i] <= finish(s_reg[i]);
            end
        end
    end

    assign valid_out = v4_reg;
    assign r00 = r_reg[0];
    assign r01 = r_reg[1];
    assign r02 = r_reg[2];
    assign r10 = r_reg[3];
    assign r11 = r_reg[4];
    assign r12 = r_reg[5];
    assign r20 = r_reg[6];
    assign r21 = r_reg[7];
    assign r22 = r_reg[8];

endmodule

// File: hw/rtl/axis_angle_to_rotation_matrix.sv
// top level: axis-angle to rotation matrix through the half-angle quaternion
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   input   | in_valid, in_stall | axis_x, axis_y, axis_z, angle
//   output  | out_valid,out_stall| r00 r01 r02 r10 r11 r12 r20 r21 r22
//
// one item per cycle sustained while out_stall is low, through one register
// per cordic cell, then quaternion, products, sums and the output register.
// every register holds its own valid flag, so bubbles close up while the
// output is stalled and new items keep entering until the chain is full.
// reset clears only the valid flags; there is no other state.
module axis_angle_to_rotation_matrix #(
    parameter int DATA_BITS     = aac_pkg::DATA_BITS_DEFAULT,
    parameter int ANGLE_BITS    = aac_pkg::ANGLE_BITS_DEFAULT,
    parameter int CORDIC_STAGES = aac_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DATA_BITS-1:0] axis_x,
    input  logic signed [DATA_BITS-1:0] axis_y,
    input  logic signed [DATA_BITS-1:0] axis_z,
    input  logic [ANGLE_BITS-1:0]       angle,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DATA_BITS-1:0] r00,
    output logic signed [DATA_BITS-1:0] r01,
    output logic signed [DATA_BITS-1:0] r02,
    output logic signed [DATA_BITS-1:0] r10,
    output logic signed [DATA_BITS-1:0] r11,
    output logic signed [DATA_BITS-1:0] r12,
    output logic signed [DATA_BITS-1:0] r20,
    output logic signed [DATA_BITS-1:0] r21,
    output logic signed [DATA_BITS-1:0] r22
);
    import aac_pkg::*;

    localparam int PHASE_SHIFT = PHASE_BITS - ANGLE_BITS;

    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] half;

    logic                      cv   [CORDIC_STAGES+1];
    logic                      crdy [CORDIC_STAGES+1];
    logic signed [XY_BITS-1:0] cx   [CORDIC_STAGES+1];
    logic signed [XY_BITS-1:0] cy   [CORDIC_STAGES+1];
    logic signed [Z_BITS-1:0]  cz   [CORDIC_STAGES+1];
    logic                      cup  [CORDIC_STAGES+1];
    logic signed [DATA_BITS-1:0] cax [CORDIC_STAGES+1];
    logic signed [DATA_BITS-1:0] cay [CORDIC_STAGES+1];
    logic signed [DATA_BITS-1:0] caz [CORDIC_STAGES+1];

    // half angle on a 32-bit turn, upper quarter folded down
    assign phase = PHASE_BITS'(angle) << PHASE_SHIFT;
    assign half  = phase >> 1;

    // head of the cordic chain
    assign cv[0]  = in_valid;
    assign in_stall = !crdy[0];
    assign cx[0]  = CORDIC_X0;
    assign cy[0]  = '0;
    assign cz[0]  = signed'({3'b000, half[29:0]});
    assign cup[0] = half[30];
    assign cax[0] = axis_x;
    assign cay[0] = axis_y;
    assign caz[0] = axis_z;

    // cordic cells, one micro-rotation each
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        aac_cordic_cell #(
            .DATA_BITS (DATA_BITS),
            .STAGE     (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (cv[i]),
            .ready_out (crdy[i]),
            .x_in      (cx[i]),
            .y_in      (cy[i]),
            .z_in      (cz[i]),
            .upper_in  (cup[i]),
            .ax_in     (cax[i]),
            .ay_in     (cay[i]),
            .az_in     (caz[i]),
            .valid_out (cv[i+1]),
            .ready_in  (crdy[i+1]),
            .x_out     (cx[i+1]),
            .y_out     (cy[i+1]),
            .z_out     (cz[i+1]),
            .upper_out (cup[i+1]),
            .ax_out    (cax[i+1]),
            .ay_out    (cay[i+1]),
            .az_out    (caz[i+1])
        );
    end

    // quaternion and matrix back end
    aac_matrix_pipe #(
        .DATA_BITS (DATA_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cv[CORDIC_STAGES]),
        .ready_out (crdy[CORDIC_STAGES]),
        .x_in      (cx[CORDIC_STAGES]),
        .y_in      (cy[CORDIC_STAGES]),
        .upper_in  (cup[CORDIC_STAGES]),
        .ax_in     (cax[CORDIC_STAGES]),
        .ay_in     (cay[CORDIC_STAGES]),
        .az_in     (caz[CORDIC_STAGES]),
        .valid_out (out_valid),
        .ready_in  (!out_stall),
        .r00       (r00),
        .r01       (r01),
        .r02       (r02),
        .r10       (r10),
        .r11       (r11),
        .r12       (r12),
        .r20       (r20),
        .r21       (r21),
        .r22       (r22)
    );

endmodule

// File: verif/axis_angle_to_rotation_matrix_tb.sv
// self-checking testbench for the axis-angle to rotation matrix pipeline
module axis_angle_to_rotation_matrix_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_BITS     = aac_pkg::DATA_BITS_DEFAULT;
    localparam int ANGLE_BITS    = aac_pkg::ANGLE_BITS_DEFAULT;
    localparam int CORDIC_STAGES = aac_pkg::CORDIC_STAGES_DEFAULT;
    localparam int LATENCY       = CORDIC_STAGES + 4;
    localparam int LONG_HOLD     = 150;
    localparam longint QUARTER_TURN = 64'h4000_0000;
    localparam int Q15_MAX       = 32767;
    localparam int Q15_MIN       = -32768;

    // one input item and one result item
    typedef struct packed {
        logic [DATA_BITS-1:0]  ax;
        logic [DATA_BITS-1:0]  ay;
        logic [DATA_BITS-1:0]  az;
        logic [ANGLE_BITS-1:0] angle;
    } axis_angle_t;

    typedef logic [0:8][DATA_BITS-1:0] matrix_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [DATA_BITS-1:0] axis_x    = '0;
    logic signed [DATA_BITS-1:0] axis_y    = '0;
    logic signed [DATA_BITS-1:0] axis_z    = '0;
    logic [ANGLE_BITS-1:0]       angle     = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [DATA_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

    // long receiver hold-offs asked for by the stimulus
    int hold_requests = 0;

    // expected matrices in arrival order, with the predictor
    class rotation_scoreboard;
        matrix_t expected_matrices[$];
        int      errors = 0;
        string   element_names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                       "r20", "r21", "r22"};

        function longint rounded_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        // round the Q.60 sum down to Q1.15 and clamp
        function logic [DATA_BITS-1:0] to_q15(longint v);
            longint r;
            r = rounded_shift(v, 61 - DATA_BITS);
            if (r > Q15_MAX)
                r = Q15_MAX;
            if (r < Q15_MIN)
                r = Q15_MIN;
            return r[DATA_BITS-1:0];
        endfunction

        function matrix_t rotation_of(axis_angle_t a);
            logic [31:0] half;
            bit          upper;
            longint      x, y, z, t, c, s, e0, e1, e2, e3;
            longint      sq0, sq1, sq2, sq3, c01, c02, c03, c12, c13, c23;
            matrix_t     m;
            // half angle in 32-bit phase, folded into the first quarter turn
            half  = {a.angle, {(32 - ANGLE_BITS){1'b0}}} >> 1;
            upper = longint'(half) >= QUARTER_TURN;
            z     = upper ? longint'(half) - QUARTER_TURN : longint'(half);
            x     = longint'(aac_pkg::CORDIC_X0);
            y     = 0;
            // rotation-mode cordic
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                t = x;
                if (z >= 0)
                begin
                    x = x - (y >>> i);
                    y = y + (t >>> i);
                    z = z - longint'(aac_pkg::ATAN_TURNS[i]);
                end
                else
                begin
                    x = x + (y >>> i);
                    y = y - (t >>> i);
                    z = z + longint'(aac_pkg::ATAN_TURNS[i]);
                end
            end
            if (upper)
            begin
                c = -y;
                s = x;
            end
            else
            begin
                c = x;
                s = y;
            end
            // quaternion
            e0 = c;
            e1 = rounded_shift(longint'($signed(a.ax)) * s, DATA_BITS - 1);
            e2 = rounded_shift(longint'($signed(a.ay)) * s, DATA_BITS - 1);
            e3 = rounded_shift(longint'($signed(a.az)) * s, DATA_BITS - 1);
            // pairwise products
            sq0 = e0 * e0;
            sq1 = e1 * e1;
            sq2 = e2 * e2;
            sq3 = e3 * e3;
            c01 = e0 * e1;
            c02 = e0 * e2;
            c03 = e0 * e3;
            c12 = e1 * e2;
            c13 = e1 * e3;
            c23 = e2 * e3;
            m[0] = to_q15(sq0 + sq1 - sq2 - sq3);
            m[1] = to_q15(2 * (c12 - c03));
            m[2] = to_q15(2 * (c13 + c02));
            m[3] = to_q15(2 * (c12 + c03));
            m[4] = to_q15(sq0 - sq1 + sq2 - sq3);
            m[5] = to_q15(2 * (c23 - c01));
            m[6] = to_q15(2 * (c13 - c02));
            m[7] = to_q15(2 * (c23 + c01));
            m[8] = to_q15(sq0 - sq1 - sq2 + sq3);
            return m;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_input(axis_angle_t a);
            expected_matrices.push_back(rotation_of(a));
        endfunction

        task check_result(matrix_t got);
            matrix_t want;
            if (expected_matrices.size() == 0)
            begin
                report("result item with no item outstanding");
                return;
            end
            want = expected_matrices.pop_front();
            for (int i = 0; i < 9; i++)
                if (got[i] !== want[i])
                    report($sformatf("%s got %0d expected %0d", element_names[i],
                                     $signed(got[i]), $signed(want[i])));
        endtask
    endclass

    rotation_scoreboard sb = new;

    axis_angle_to_rotation_matrix uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .axis_z    (axis_z),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .r00       (r00),
        .r01       (r01),
        .r02       (r02),
        .r10       (r10),
        .r11       (r11),
        .r12       (r12),
        .r20       (r20),
        .r21       (r21),
        .r22       (r22)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall === 1'b0)
            sb.note_input('{axis_x, axis_y, axis_z, angle});
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_result({r00, r01, r02, r10, r11, r12, r20, r21, r22});
    end

    // receiver: stall pattern changes by segment, long hold-off on request
    initial
    begin : receiver
        int mode;
        int seg;
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            while (seg > 0)
            begin
                @(posedge clk);
                if (hold_left > 0)
                begin
                    out_stall <= 1'b1;
                    hold_left--;
                end
                else if (hold_requests != served)
                begin
                    served++;
                    hold_left = LONG_HOLD - 1;
                    out_stall <= 1'b1;
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= seg[3];
                    endcase
                end
                seg--;
            end
        end
    end

    function automatic axis_angle_t make_item(int x, int y, int z, int a);
        axis_angle_t it;
        it.ax    = x[DATA_BITS-1:0];
        it.ay    = y[DATA_BITS-1:0];
        it.az    = z[DATA_BITS-1:0];
        it.angle = a[ANGLE_BITS-1:0];
        return it;
    endfunction

    function automatic int corner_value();
        case ($urandom_range(0, 3))
            0: return Q15_MIN;
            1: return Q15_MAX;
            2: return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // mostly unit axes, some raw bit patterns and corner components
    function automatic axis_angle_t random_item();
        int  pick;
        int  a;
        real vx, vy, vz, norm;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 4))
                0: a = 0;
                1: a = 16'h4000;
                2: a = 16'h7FFF;
                3: a = 16'h8000;
                default: a = 16'hFFFF;
            endcase
        end
        else
            a = $urandom_range(0, 65535);
        if (pick <= 5)
        begin
            norm = 0.0;
            while (norm < 1000.0)
            begin
                vx   = real'(int'($urandom_range(0, 65535)) - 32768);
                vy   = real'(int'($urandom_range(0, 65535)) - 32768);
                vz   = real'(int'($urandom_range(0, 65535)) - 32768);
                norm = $sqrt(vx * vx + vy * vy + vz * vz);
            end
            return make_item(int'(vx * 32767.0 / norm), int'(vy * 32767.0 / norm),
                             int'(vz * 32767.0 / norm), a);
        end
        else if (pick <= 8)
            return make_item($urandom, $urandom, $urandom, a);
        else
            return make_item(corner_value(), corner_value(), corner_value(), a);
    endfunction

    // hold one item on the input until it is taken
    task automatic offer(input axis_angle_t it);
        in_valid <= 1'b1;
        axis_x   <= it.ax;
        axis_y   <= it.ay;
        axis_z   <= it.az;
        angle    <= it.angle;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic idle(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // sender stops and waits until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_matrices.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_random(input int count, input bit gapless);
        int left;
        int run;
        int gap;
        left = count;
        while (left > 0)
        begin
            run = $urandom_range(1, 30);
            if (run > left)
                run = left;
            repeat (run)
            begin
                offer(random_item());
                left--;
            end
            if (!gapless && left > 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    idle(gap);
            end
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        axis_angle_t directed[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axis extremes, quadrant boundaries of the half angle, diagonal axes,
        // zero axis, and over-long axes that push elements into saturation
        directed.push_back(make_item(32767, 0, 0, 16'h0000));
        directed.push_back(make_item(32767, 0, 0, 16'h4000));
        directed.push_back(make_item(0, 32767, 0, 16'h8000));
        directed.push_back(make_item(0, 0, 32767, 16'hC000));
        directed.push_back(make_item(0, 0, Q15_MIN, 16'hFFFF));
        directed.push_back(make_item(Q15_MIN, 0, 0, 16'h7FFF));
        directed.push_back(make_item(0, Q15_MIN, 0, 16'h8001));
        directed.push_back(make_item(18919, 18919, 18919, 16'h5555));
        directed.push_back(make_item(-18919, 18919, -18919, 16'hAAAA));
        directed.push_back(make_item(32767, 32767, 32767, 16'h4000));
        directed.push_back(make_item(Q15_MIN, Q15_MIN, Q15_MIN, 16'h8000));
        directed.push_back(make_item(0, 0, 0, 16'h8000));
        directed.push_back(make_item(0, 0, 0, 16'h0000));
        directed.push_back(make_item(32767, Q15_MIN, 32767, 16'hFFFF));
        directed.push_back(make_item(23170, 23170, 0, 16'h2000));
        directed.push_back(make_item(0, 23170, -23170, 16'h6000));
        directed.push_back(make_item(1, -1, 1, 16'h0001));
        directed.push_back(make_item(-1, 1, -1, 16'hFFFE));
        foreach (directed[i])
            offer(directed[i]);
        drain();

        send_random(150, 1'b0);
        // receiver holds off while items keep coming, so the pipe backs up
        hold_requests <= hold_requests + 1;
        send_random(60, 1'b1);
        drain();
        send_random(240, 1'b0);
        drain();

        repeat (LATENCY + 10) @(posedge clk);
        if (sb.expected_matrices.size() != 0)
            sb.report($sformatf("%0d result items never arrived",
                                sb.expected_matrices.size()));
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : watchdog
        #(2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/aac_pkg.sv
hw/rtl/aac_cordic_cell.sv
hw/rtl/aac_matrix_pipe.sv
hw/rtl/axis_angle_to_rotation_matrix.sv
verif/axis_angle_to_rotation_matrix_tb.sv
